// ----- rtl/core/script_statement_stream_walker_top_assert.svh -----
// Assertion macros for the statement stream walker.
// Used by the walker and result queue modules; empty when SYNTHESIS is defined.
`ifndef SCRIPT_STATEMENT_STREAM_WALKER_TOP_ASSERT_SVH
`define SCRIPT_STATEMENT_STREAM_WALKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define SSSW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sssw assertion failed");
// consequent checked in the cycle after the antecedent
`define SSSW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sssw assertion failed");
`else
`define SSSW_ASSERT(lbl, clk, rst, prop)
`define SSSW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/sssw_pkg.sv -----
// Shared types and constants of the statement stream walker.
// No dependencies; used by every module of the block.
`default_nettype none

package sssw_pkg;

   // default parameter values
   localparam int OFFSET_BITS_DEF = 24;
   localparam int MAX_NEST_DEF    = 32;

   // output field widths
   localparam int CNT_W = 23;
   localparam int LEN_W = 24;
   localparam int FUO_W = 25;
   localparam logic [CNT_W-1:0] CNT_MAX = 23'h7FFFFF;

   // token and opcode codes
   localparam logic [15:0] TOK_OPEN_LO = 16'h0200;
   localparam logic [15:0] TOK_OPEN_HI = 16'h0202;
   localparam logic [15:0] TOK_END     = 16'h020F;
   localparam logic [15:0] TOK_STRING  = 16'h0120;
   localparam logic [15:0] OP_JUMP     = 16'h0400;
   localparam logic [15:0] CMD_LO      = 16'h2000;
   localparam logic [15:0] CMD_HI      = 16'h27FF;
   localparam logic [15:0] OPR_LO      = 16'h0160;
   localparam logic [15:0] OPR_HI      = 16'h017E;
   localparam logic [15:0] CTL_LO      = 16'h0401;
   localparam logic [15:0] CTL_HI      = 16'h0442;

   // operand words after a jump opcode
   localparam logic [2:0] JUMP_SKIP = 3'd2;

   // result queue depth
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_EXPR  = 2'd1,
      MODE_SKIP  = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_EXPR = 3'd0,
      KIND_JUMP = 3'd1,
      KIND_CTRL = 3'd2,
      KIND_CMD  = 3'd3,
      KIND_UNK  = 3'd4
   } kind_type;

   // word classification from the decoder
   typedef struct packed {
      logic       is_open;
      logic       is_end;
      logic       is_string;
      logic       is_jump;
      logic       is_ctrl;
      logic       is_cmd;
      logic [2:0] tok_skip;
      logic [2:0] ctl_skip;
   } dec_type;

   // one result record
   typedef struct packed {
      logic                    record_type;
      logic                    last_of_run;
      kind_type                stmt_kind;
      logic [15:0]             opcode;
      logic [LEN_W-1:0]        stmt_length;
      logic [CNT_W-1:0]        string_count;
      logic [CNT_W-1:0]        statement_total;
      logic [CNT_W-1:0]        command_total;
      logic [CNT_W-1:0]        expression_total;
      logic [CNT_W-1:0]        unknown_total;
      logic signed [FUO_W-1:0] first_unknown_offset;
      logic                    walk_ok;
   } rec_type;

endpackage

`default_nettype wire

// ----- rtl/core/sssw_decode.sv -----
// Word classifier: token class and operand lengths of one code word.
// Depends on sssw_pkg.
`default_nettype none

module sssw_decode (
   input  wire logic [15:0]     code_word,
   output sssw_pkg::dec_type    dec
);

   // operand words after an expression token
   function automatic logic [2:0] tok_skip(input logic [15:0] t);
      logic [2:0] r;
      priority if (t == 16'h0101 || t == 16'h0102 || t == 16'h012B) r = 3'd0;
      else if (t == 16'h0107 || t == 16'h010B || t == 16'h0111 || t == 16'h0113) r = 3'd3;
      else if (t == 16'h0105 || t == 16'h0109 || t == 16'h0110 || t == 16'h0112 ||
               t == 16'h012A || t == 16'h012D || t == 16'h012F) r = 3'd2;
      else if (t >= sssw_pkg::OPR_LO && t <= sssw_pkg::OPR_HI) r = 3'd0;
      else r = 3'd2;
      return r;
   endfunction

   // operand words after a control opcode
   function automatic logic [2:0] ctl_skip(input logic [15:0] op);
      logic [2:0] r;
      unique case (op)
         16'h0401, 16'h0402: r = 3'd2;
         16'h0403: r = 3'd4;
         16'h0405, 16'h0407, 16'h0410, 16'h0411, 16'h0412: r = 3'd1;
         16'h0440, 16'h0442: r = 3'd3;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   always_comb begin
      dec.is_open   = (code_word >= sssw_pkg::TOK_OPEN_LO) && (code_word <= sssw_pkg::TOK_OPEN_HI);
      dec.is_end    = (code_word == sssw_pkg::TOK_END);
      dec.is_string = (code_word == sssw_pkg::TOK_STRING);
      dec.is_jump   = (code_word == sssw_pkg::OP_JUMP);
      dec.is_ctrl   = (code_word >= sssw_pkg::CTL_LO) && (code_word <= sssw_pkg::CTL_HI);
      dec.is_cmd    = (code_word >= sssw_pkg::CMD_LO) && (code_word <= sssw_pkg::CMD_HI);
      dec.tok_skip  = tok_skip(code_word);
      dec.ctl_skip  = ctl_skip(code_word);
   end

endmodule

`default_nettype wire

// ----- rtl/core/sssw_walker.sv -----
// Walk state and record builder: updates parse state per accepted word and
// forms up to two records. Depends on sssw_pkg and the assertion header.
`default_nettype none
`include "script_statement_stream_walker_top_assert.svh"

module sssw_walker #(
   parameter int OFFSET_BITS = sssw_pkg::OFFSET_BITS_DEF,
   parameter int MAX_NEST    = sssw_pkg::MAX_NEST_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [15:0]       code_word,
   input  wire logic              last_word,
   input  wire logic              lone_byte,
   input  wire sssw_pkg::dec_type dec,
   output logic [1:0]             rec_num,
   output sssw_pkg::rec_type      rec0,
   output sssw_pkg::rec_type      rec1
);

   localparam int OW     = OFFSET_BITS;
   localparam int NEST_W = $clog2(MAX_NEST + 1);
   localparam int CW     = sssw_pkg::CNT_W;

   sssw_pkg::mode_type mode_ff, mode_in;
   sssw_pkg::kind_type kind_ff, kind_in;
   logic [2:0]         skip_ff, skip_in;
   logic [NEST_W-1:0]  nest_ff, nest_in;
   logic [15:0]        op_ff, op_in;
   logic [OW-1:0]      off_ff, off_in;
   logic [OW-1:0]      start_ff, start_in;
   logic [CW-1:0]      strs_ff, strs_in;
   logic [CW-1:0]      tot_stmt_ff, tot_stmt_in;
   logic [CW-1:0]      tot_cmd_ff, tot_cmd_in;
   logic [CW-1:0]      tot_expr_ff, tot_expr_in;
   logic [CW-1:0]      tot_unk_ff, tot_unk_in;
   logic [CW-1:0]      tot_str_ff, tot_str_in;
   logic               seen_ff, seen_in;
   logic [OW-1:0]      upos_ff, upos_in;
   logic [15:0]        uop_ff, uop_in;

   logic               done;
   logic               last;
   logic [OW-1:0]      end_off;
   logic [OW-1:0]      stmt_len;
   logic [2:0]         skip_dec;
   logic [CW:0]        str_sum;
   sssw_pkg::rec_type  stmt_rec;
   sssw_pkg::rec_type  sum_rec;

   // saturating increment of a counter
   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
      return (x == sssw_pkg::CNT_MAX) ? x : x + CW'(1);
   endfunction

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sssw_pkg::MODE_START;
         kind_ff     <= sssw_pkg::KIND_EXPR;
         skip_ff     <= '0;
         nest_ff     <= '0;
         op_ff       <= '0;
         off_ff      <= '0;
         start_ff    <= '0;
         strs_ff     <= '0;
         tot_stmt_ff <= '0;
         tot_cmd_ff  <= '0;
         tot_expr_ff <= '0;
         tot_unk_ff  <= '0;
         tot_str_ff  <= '0;
         seen_ff     <= 1'b0;
         upos_ff     <= '0;
         uop_ff      <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         kind_ff     <= kind_in;
         skip_ff     <= skip_in;
         nest_ff     <= nest_in;
         op_ff       <= op_in;
         off_ff      <= off_in;
         start_ff    <= start_in;
         strs_ff     <= strs_in;
         tot_stmt_ff <= tot_stmt_in;
         tot_cmd_ff  <= tot_cmd_in;
         tot_expr_ff <= tot_expr_in;
         tot_unk_ff  <= tot_unk_in;
         tot_str_ff  <= tot_str_in;
         seen_ff     <= seen_in;
         upos_ff     <= upos_in;
         uop_ff      <= uop_in;
      end
   end

   // next state and records for the word at the input
   always_comb begin
      mode_in     = mode_ff;
      kind_in     = kind_ff;
      skip_in     = skip_ff;
      nest_in     = nest_ff;
      op_in       = op_ff;
      off_in      = off_ff;
      start_in    = start_ff;
      strs_in     = strs_ff;
      tot_stmt_in = tot_stmt_ff;
      tot_cmd_in  = tot_cmd_ff;
      tot_expr_in = tot_expr_ff;
      tot_unk_in  = tot_unk_ff;
      tot_str_in  = tot_str_ff;
      seen_in     = seen_ff;
      upos_in     = upos_ff;
      uop_in      = uop_ff;
      done        = 1'b0;
      last        = last_word | lone_byte;
      end_off     = off_ff + OW'(2);
      stmt_len    = '0;
      skip_dec    = '0;
      str_sum     = '0;
      stmt_rec    = '0;
      sum_rec     = '0;

      // parse step
      if (mode_ff != sssw_pkg::MODE_STOP) begin
         if (lone_byte) begin
            if (mode_ff != sssw_pkg::MODE_START) mode_in = sssw_pkg::MODE_STOP;
            off_in = off_ff + OW'(1);
         end else begin
            unique case (mode_ff)
               sssw_pkg::MODE_START: begin
                  start_in = off_ff;
                  op_in    = code_word;
                  strs_in  = '0;
                  nest_in  = '0;
                  skip_in  = '0;
                  priority if (dec.is_open) begin
                     kind_in = sssw_pkg::KIND_EXPR;
                     mode_in = sssw_pkg::MODE_EXPR;
                  end else if (dec.is_jump) begin
                     kind_in = sssw_pkg::KIND_JUMP;
                     skip_in = sssw_pkg::JUMP_SKIP;
                     mode_in = sssw_pkg::MODE_SKIP;
                  end else if (dec.is_ctrl) begin
                     kind_in = sssw_pkg::KIND_CTRL;
                     skip_in = dec.ctl_skip;
                     if (dec.ctl_skip == '0) done = 1'b1;
                     else mode_in = sssw_pkg::MODE_SKIP;
                  end else if (dec.is_cmd) begin
                     kind_in = sssw_pkg::KIND_CMD;
                     done    = 1'b1;
                  end else begin
                     kind_in = sssw_pkg::KIND_UNK;
                     done    = 1'b1;
                  end
               end
               sssw_pkg::MODE_EXPR: begin
                  priority if (dec.is_end) begin
                     if (nest_ff == '0) done = 1'b1;
                     else nest_in = nest_ff - NEST_W'(1);
                  end else if (dec.is_open) begin
                     if (nest_ff == NEST_W'(MAX_NEST)) mode_in = sssw_pkg::MODE_STOP;
                     else nest_in = nest_ff + NEST_W'(1);
                  end else begin
                     if (dec.is_string) strs_in = sat_inc(strs_ff);
                     skip_in = dec.tok_skip;
                     if (dec.tok_skip != '0) mode_in = sssw_pkg::MODE_SKIP;
                  end
               end
               sssw_pkg::MODE_SKIP: begin
                  skip_dec = (skip_ff != '0) ? skip_ff - 3'd1 : skip_ff;
                  skip_in  = skip_dec;
                  if (skip_dec == '0) begin
                     if (kind_ff == sssw_pkg::KIND_EXPR) mode_in = sssw_pkg::MODE_EXPR;
                     else done = 1'b1;
                  end
               end
               sssw_pkg::MODE_STOP: begin
               end
            endcase
            off_in = end_off;
         end
      end

      // statement finished: totals, first unknown, statement record
      if (done) begin
         tot_stmt_in = sat_inc(tot_stmt_ff);
         str_sum     = {1'b0, tot_str_ff} + {1'b0, strs_in};
         tot_str_in  = (str_sum > {1'b0, sssw_pkg::CNT_MAX}) ? sssw_pkg::CNT_MAX
                                                             : str_sum[CW-1:0];
         if (kind_in == sssw_pkg::KIND_CMD) tot_cmd_in = sat_inc(tot_cmd_ff);
         if (kind_in == sssw_pkg::KIND_EXPR) tot_expr_in = sat_inc(tot_expr_ff);
         if (kind_in == sssw_pkg::KIND_UNK) begin
            tot_unk_in = sat_inc(tot_unk_ff);
            if (!seen_ff) begin
               seen_in = 1'b1;
               upos_in = start_in;
               uop_in  = op_in;
            end
         end
         // length wraps at the offset width
         stmt_len = end_off - start_in;
         stmt_rec.record_type          = 1'b0;
         stmt_rec.stmt_kind            = kind_in;
         stmt_rec.opcode               = op_in;
         stmt_rec.stmt_length          = sssw_pkg::LEN_W'(stmt_len);
         stmt_rec.string_count         = strs_in;
         stmt_rec.statement_total      = tot_stmt_in;
         stmt_rec.command_total        = tot_cmd_in;
         stmt_rec.expression_total     = tot_expr_in;
         stmt_rec.unknown_total        = tot_unk_in;
         stmt_rec.first_unknown_offset = seen_in ? sssw_pkg::FUO_W'(upos_in) : '1;
         stmt_rec.walk_ok              = 1'b0;
         start_in = end_off;
         mode_in  = sssw_pkg::MODE_START;
      end

      // final word: summary record, then a fresh walk
      if (last) begin
         sum_rec.record_type          = 1'b1;
         sum_rec.stmt_kind            = sssw_pkg::KIND_EXPR;
         sum_rec.opcode               = seen_in ? uop_in : 16'h0000;
         sum_rec.stmt_length          = sssw_pkg::LEN_W'(start_in);
         sum_rec.string_count         = tot_str_in;
         sum_rec.statement_total      = tot_stmt_in;
         sum_rec.command_total        = tot_cmd_in;
         sum_rec.expression_total     = tot_expr_in;
         sum_rec.unknown_total        = tot_unk_in;
         sum_rec.first_unknown_offset = seen_in ? sssw_pkg::FUO_W'(upos_in) : '1;
         sum_rec.walk_ok              = (mode_in == sssw_pkg::MODE_START) && !lone_byte &&
                                        (tot_unk_in == '0);
         sum_rec.last_of_run          = 1'b1;
         mode_in     = sssw_pkg::MODE_START;
         kind_in     = sssw_pkg::KIND_EXPR;
         skip_in     = '0;
         nest_in     = '0;
         op_in       = '0;
         off_in      = '0;
         start_in    = '0;
         strs_in     = '0;
         tot_stmt_in = '0;
         tot_cmd_in  = '0;
         tot_expr_in = '0;
         tot_unk_in  = '0;
         tot_str_in  = '0;
         seen_in     = 1'b0;
         upos_in     = '0;
         uop_in      = '0;
      end
      stmt_rec.last_of_run = !last;

      // record selection
      if (done) begin
         rec0 = stmt_rec;
         rec1 = sum_rec;
      end else begin
         rec0 = sum_rec;
         rec1 = sum_rec;
      end
      if (!accept) rec_num = 2'd0;
      else rec_num = {1'b0, done} + {1'b0, last};
   end

   `SSSW_ASSERT(a_nest_bound, clock, reset, nest_ff <= NEST_W'(MAX_NEST))
   `SSSW_ASSERT(a_final_word_reports, clock, reset, (accept && last) |-> (rec_num != 2'd0))
   `SSSW_ASSERT_NEXT(a_walk_restarts, clock, reset, accept && last, (off_ff == '0) && !seen_ff)

endmodule

`default_nettype wire

// ----- rtl/core/sssw_outq.sv -----
// Result queue: holds up to four records, takes one or two per cycle while it has
// room for two, and hands one per transfer to the result channel. Depends on sssw_pkg.
`default_nettype none
`include "script_statement_stream_walker_top_assert.svh"

module sssw_outq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        push_num,
   input  wire sssw_pkg::rec_type rec0,
   input  wire sssw_pkg::rec_type rec1,
   output logic                   space_ok,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output sssw_pkg::rec_type      head
);

   localparam int DEPTH = sssw_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sssw_pkg::rec_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign head       = mem_ff[head_ff];
   // room for two records whatever the receiver does
   assign space_ok   = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      head_in  = head_ff + PTR_W'(pop);
      tail_in  = tail_ff + PTR_W'(push_num);
      count_in = count_ff + CNT_W'(push_num) - CNT_W'(pop);
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // record storage
   always_ff @(posedge clock) begin
      if (push_num != 2'd0) mem_ff[tail_ff] <= rec0;
      if (push_num == 2'd2) mem_ff[tail_ff + PTR_W'(1)] <= rec1;
   end

   `SSSW_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `SSSW_ASSERT(a_push_has_room, clock, reset, (push_num != 2'd0) |-> (count_ff <= CNT_W'(DEPTH - 2)))
   `SSSW_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready && push_num == 2'd0, count_ff == $past(count_ff) && head_ff == $past(head_ff))

endmodule

`default_nettype wire

// ----- rtl/core/script_statement_stream_walker_top.sv -----
// Statement stream walker: bytecode words in, statement and summary records out.
// Uses sssw_pkg, sssw_decode, sssw_walker and sssw_outq.
//
// req channel: one 16-bit code word per transfer (first byte in the low half),
//   req_tlast marks the final word of the code, req_tuser marks a lone low byte
//   (odd code length, also taken as the final word).
// rsp channel: one record per transfer. rsp_tuser is 1 for the walk summary,
//   0 for a statement record; rsp_tlast marks the last record of one word.
// A word gives zero, one or two records. The walk state is updated in the
//   cycle a word is taken; its records enter the result queue in that cycle.
// Throughput: one word per cycle while rsp_tready stays high and each word gives
//   at most one record; words that give two fill up the four-entry result queue.
// req_tready is high while the queue has room for two records, so a stalled
//   receiver halts input after three or four records back up; nothing is lost.
// Reset (synchronous, active high) empties the queue and starts a new walk.
// After each summary the walk restarts at byte offset zero.
`default_nettype none

module script_statement_stream_walker_top #(
   parameter int OFFSET_BITS = sssw_pkg::OFFSET_BITS_DEF,
   parameter int MAX_NEST    = sssw_pkg::MAX_NEST_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] code_word
   input  wire logic         req_tlast,   // last_word
   input  wire logic         req_tuser,   // [0] lone_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [2:0] stmt_kind, [18:3] opcode, [42:19] stmt_length, [65:43] string_count,
   // [88:66] statement_total, [111:89] command_total, [134:112] expression_total,
   // [157:135] unknown_total, [182:158] first_unknown_offset, [183] walk_ok
   output logic [183:0]      rsp_tdata,
   output logic              rsp_tlast,   // last_of_run
   output logic              rsp_tuser    // [0] record_type
);

   sssw_pkg::dec_type dec;
   sssw_pkg::rec_type rec0;
   sssw_pkg::rec_type rec1;
   sssw_pkg::rec_type head;
   logic [1:0]        rec_num;
   logic              accept;

   assign accept = req_tvalid & req_tready;

   sssw_decode u_decode (
      .code_word (req_tdata),
      .dec       (dec)
   );

   sssw_walker #(
      .OFFSET_BITS (OFFSET_BITS),
      .MAX_NEST    (MAX_NEST)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_word (req_tdata),
      .last_word (req_tlast),
      .lone_byte (req_tuser),
      .dec       (dec),
      .rec_num   (rec_num),
      .rec0      (rec0),
      .rec1      (rec1)
   );

   sssw_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_num   (rec_num),
      .rec0       (rec0),
      .rec1       (rec1),
      .space_ok   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   // pack the head record onto the result channel
   assign rsp_tdata = {head.walk_ok, head.first_unknown_offset, head.unknown_total,
                       head.expression_total, head.command_total, head.statement_total,
                       head.string_count, head.stmt_length, head.opcode, head.stmt_kind};
   assign rsp_tlast = head.last_of_run;
   assign rsp_tuser = head.record_type;

endmodule

`default_nettype wire

// ----- tb/tb_script_statement_stream_walker_top.sv -----
// Self-checking testbench for script_statement_stream_walker_top.
// Drives bytecode walks on the req stream and checks every record on the rsp
// stream against a local predictor of the walker. Depends on sssw_pkg.
`timescale 1ns / 1ps

module tb_script_statement_stream_walker_top;

   // expression tokens by operand count
   localparam logic [15:0] TOK_NOARG_A = 16'h0101;
   localparam logic [15:0] TOK_NOARG_B = 16'h0102;
   localparam logic [15:0] TOK_NOARG_C = 16'h012B;
   localparam logic [15:0] TOK_ARG3_A  = 16'h0107;
   localparam logic [15:0] TOK_ARG3_B  = 16'h010B;
   localparam logic [15:0] TOK_ARG3_C  = 16'h0111;
   localparam logic [15:0] TOK_ARG3_D  = 16'h0113;
   localparam logic [15:0] TOK_ARG2_A  = 16'h0105;
   localparam logic [15:0] TOK_ARG2_B  = 16'h0109;
   localparam logic [15:0] TOK_ARG2_C  = 16'h0110;
   localparam logic [15:0] TOK_ARG2_D  = 16'h0112;
   localparam logic [15:0] TOK_ARG2_E  = 16'h012A;
   localparam logic [15:0] TOK_ARG2_F  = 16'h012D;
   localparam logic [15:0] TOK_ARG2_G  = 16'h012F;
   localparam logic [15:0] TOK_SCAN_LO = 16'h0100;
   localparam logic [15:0] TOK_SCAN_HI = 16'h012F;

   // control opcodes by operand count
   localparam logic [15:0] CTL_ARG2_A = 16'h0401;
   localparam logic [15:0] CTL_ARG2_B = 16'h0402;
   localparam logic [15:0] CTL_ARG4   = 16'h0403;
   localparam logic [15:0] CTL_NOARG  = 16'h0404;
   localparam logic [15:0] CTL_ARG1_A = 16'h0405;
   localparam logic [15:0] CTL_ARG1_B = 16'h0407;
   localparam logic [15:0] CTL_ARG1_C = 16'h0410;
   localparam logic [15:0] CTL_ARG1_D = 16'h0411;
   localparam logic [15:0] CTL_ARG1_E = 16'h0412;
   localparam logic [15:0] CTL_ARG3_A = 16'h0440;
   localparam logic [15:0] CTL_ARG3_B = 16'h0442;

   localparam logic [15:0] OP_UNKNOWN_TOP = 16'hFFFF;

   localparam int NEST_LIMIT  = sssw_pkg::MAX_NEST_DEF;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;
   logic         rsp_tlast;
   logic         rsp_tuser;

   script_statement_stream_walker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // idle percentages for each side
   int send_idle = 0;
   int recv_idle = 0;

   // run statistics
   int mismatches    = 0;
   int words_sent    = 0;
   int walks_sent    = 0;
   int stmt_checked  = 0;
   int summ_checked  = 0;
   int quiet_cycles  = 0;

   // records still to come from the block, oldest first
   sssw_pkg::rec_type pending_records[$];

   // ------------------------------------------------------------------
   // walker predictor state
   sssw_pkg::mode_type wk_mode;
   logic [2:0]         wk_skip;
   int                 wk_depth;
   logic [15:0]        wk_op;
   sssw_pkg::kind_type wk_kind;
   logic [23:0]        wk_offset;
   logic [23:0]        wk_stmt_start;
   logic [22:0]        wk_strings;
   logic [22:0]        tot_stmt, tot_cmd, tot_expr, tot_unk, tot_str;
   bit                 unk_seen;
   logic [23:0]        unk_pos;
   logic [15:0]        unk_op;

   function automatic void walk_clear();
      wk_mode = sssw_pkg::MODE_START;
      wk_skip = '0;
      wk_depth = 0;
      wk_op = '0;
      wk_kind = sssw_pkg::KIND_EXPR;
      wk_offset = '0;
      wk_stmt_start = '0;
      wk_strings = '0;
      tot_stmt = '0;
      tot_cmd = '0;
      tot_expr = '0;
      tot_unk = '0;
      tot_str = '0;
      unk_seen = 1'b0;
      unk_pos = '0;
      unk_op = '0;
   endfunction

   function automatic logic [22:0] sat_add(logic [22:0] a, logic [22:0] b);
      logic [23:0] s;
      s = a + b;
      return (s > sssw_pkg::CNT_MAX) ? sssw_pkg::CNT_MAX : s[22:0];
   endfunction

   // operand words after an expression token
   function automatic logic [2:0] tok_args(logic [15:0] t);
      case (t)
         TOK_NOARG_A, TOK_NOARG_B, TOK_NOARG_C: return 3'd0;
         TOK_ARG3_A, TOK_ARG3_B, TOK_ARG3_C, TOK_ARG3_D: return 3'd3;
         TOK_ARG2_A, TOK_ARG2_B, TOK_ARG2_C, TOK_ARG2_D,
         TOK_ARG2_E, TOK_ARG2_F, TOK_ARG2_G: return 3'd2;
         default: return (t >= sssw_pkg::OPR_LO && t <= sssw_pkg::OPR_HI) ? 3'd0 : 3'd2;
      endcase
   endfunction

   // operand words after a control opcode
   function automatic logic [2:0] ctl_args(logic [15:0] op);
      case (op)
         CTL_ARG2_A, CTL_ARG2_B: return 3'd2;
         CTL_ARG4: return 3'd4;
         CTL_ARG1_A, CTL_ARG1_B, CTL_ARG1_C, CTL_ARG1_D, CTL_ARG1_E: return 3'd1;
         CTL_ARG3_A, CTL_ARG3_B: return 3'd3;
         default: return 3'd0;
      endcase
   endfunction

   function automatic sssw_pkg::rec_type make_record(bit summary, sssw_pkg::kind_type kind,
                                                     logic [15:0] op, logic [23:0] len,
                                                     logic [22:0] strs, bit ok);
      sssw_pkg::rec_type r;
      r.record_type = summary;
      r.last_of_run = 1'b0;
      r.stmt_kind = kind;
      r.opcode = op;
      r.stmt_length = len;
      r.string_count = strs;
      r.statement_total = tot_stmt;
      r.command_total = tot_cmd;
      r.expression_total = tot_expr;
      r.unknown_total = tot_unk;
      r.first_unknown_offset = unk_seen ? {1'b0, unk_pos} : '1;
      r.walk_ok = ok;
      return r;
   endfunction

   // close the current statement at byte offset stop_at
   function automatic sssw_pkg::rec_type finish_stmt(logic [23:0] stop_at);
      sssw_pkg::rec_type r;
      tot_stmt = sat_add(tot_stmt, 23'd1);
      tot_str = sat_add(tot_str, wk_strings);
      if (wk_kind == sssw_pkg::KIND_CMD) begin
         tot_cmd = sat_add(tot_cmd, 23'd1);
      end else if (wk_kind == sssw_pkg::KIND_EXPR) begin
         tot_expr = sat_add(tot_expr, 23'd1);
      end else if (wk_kind == sssw_pkg::KIND_UNK) begin
         tot_unk = sat_add(tot_unk, 23'd1);
         if (!unk_seen) begin
            unk_seen = 1'b1;
            unk_pos = wk_stmt_start;
            unk_op = wk_op;
         end
      end
      r = make_record(1'b0, wk_kind, wk_op, stop_at - wk_stmt_start, wk_strings, 1'b0);
      wk_stmt_start = stop_at;
      wk_mode = sssw_pkg::MODE_START;
      return r;
   endfunction

   // advance the walk by one accepted word and queue the records it causes
   function automatic void predict_word(logic [15:0] w, bit last_in, bit lone);
      sssw_pkg::rec_type made [2];
      int                n;
      bit                last;
      bit                ok;
      logic [23:0]       stop_at;
      n = 0;
      last = lone || last_in;
      if (wk_mode != sssw_pkg::MODE_STOP) begin
         if (lone) begin
            if (wk_mode != sssw_pkg::MODE_START) wk_mode = sssw_pkg::MODE_STOP;
            wk_offset = wk_offset + 24'd1;
         end else begin
            stop_at = wk_offset + 24'd2;
            case (wk_mode)
               sssw_pkg::MODE_START: begin
                  wk_stmt_start = wk_offset;
                  wk_op = w;
                  wk_strings = '0;
                  wk_depth = 0;
                  wk_skip = '0;
                  if (w >= sssw_pkg::TOK_OPEN_LO && w <= sssw_pkg::TOK_OPEN_HI) begin
                     wk_kind = sssw_pkg::KIND_EXPR;
                     wk_mode = sssw_pkg::MODE_EXPR;
                  end else if (w == sssw_pkg::OP_JUMP) begin
                     wk_kind = sssw_pkg::KIND_JUMP;
                     wk_skip = sssw_pkg::JUMP_SKIP;
                     wk_mode = sssw_pkg::MODE_SKIP;
                  end else if (w >= sssw_pkg::CTL_LO && w <= sssw_pkg::CTL_HI) begin
                     wk_kind = sssw_pkg::KIND_CTRL;
                     wk_skip = ctl_args(w);
                     if (wk_skip == 0) begin
                        made[n] = finish_stmt(stop_at);
                        n++;
                     end else begin
                        wk_mode = sssw_pkg::MODE_SKIP;
                     end
                  end else if (w >= sssw_pkg::CMD_LO && w <= sssw_pkg::CMD_HI) begin
                     wk_kind = sssw_pkg::KIND_CMD;
                     made[n] = finish_stmt(stop_at);
                     n++;
                  end else begin
                     wk_kind = sssw_pkg::KIND_UNK;
                     made[n] = finish_stmt(stop_at);
                     n++;
                  end
               end
               sssw_pkg::MODE_EXPR: begin
                  if (w == sssw_pkg::TOK_END) begin
                     if (wk_depth == 0) begin
                        made[n] = finish_stmt(stop_at);
                        n++;
                     end else begin
                        wk_depth--;
                     end
                  end else if (w >= sssw_pkg::TOK_OPEN_LO && w <= sssw_pkg::TOK_OPEN_HI) begin
                     if (wk_depth + 1 > NEST_LIMIT) wk_mode = sssw_pkg::MODE_STOP;
                     else wk_depth++;
                  end else begin
                     if (w == sssw_pkg::TOK_STRING) wk_strings = sat_add(wk_strings, 23'd1);
                     wk_skip = tok_args(w);
                     if (wk_skip != 0) wk_mode = sssw_pkg::MODE_SKIP;
                  end
               end
               default: begin
                  if (wk_skip > 0) wk_skip--;
                  if (wk_skip == 0) begin
                     if (wk_kind == sssw_pkg::KIND_EXPR) begin
                        wk_mode = sssw_pkg::MODE_EXPR;
                     end else begin
                        made[n] = finish_stmt(stop_at);
                        n++;
                     end
                  end
               end
            endcase
            wk_offset = stop_at;
         end
      end
      // end of code: summary record, then a fresh walk
      if (last) begin
         if (wk_mode != sssw_pkg::MODE_START) wk_mode = sssw_pkg::MODE_STOP;
         ok = (wk_mode == sssw_pkg::MODE_START) && !lone && (tot_unk == 0);
         made[n] = make_record(1'b1, sssw_pkg::KIND_EXPR, unk_seen ? unk_op : 16'h0000,
                               wk_stmt_start, tot_str, ok);
         n++;
         walk_clear();
      end
      if (n > 0) made[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) pending_records.push_back(made[i]);
   endfunction

   // ------------------------------------------------------------------
   // result checking
   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_record();
      sssw_pkg::rec_type want;
      sssw_pkg::rec_type got;
      got.record_type = rsp_tuser;
      got.last_of_run = rsp_tlast;
      got.stmt_kind = sssw_pkg::kind_type'(rsp_tdata[2:0]);
      got.opcode = rsp_tdata[18:3];
      got.stmt_length = rsp_tdata[42:19];
      got.string_count = rsp_tdata[65:43];
      got.statement_total = rsp_tdata[88:66];
      got.command_total = rsp_tdata[111:89];
      got.expression_total = rsp_tdata[134:112];
      got.unknown_total = rsp_tdata[157:135];
      got.first_unknown_offset = rsp_tdata[182:158];
      got.walk_ok = rsp_tdata[183];
      if (pending_records.size() == 0) begin
         $display("%0t: record with nothing expected, expected none, actual %h",
                  $time, rsp_tdata);
         mismatches++;
      end else begin
         want = pending_records.pop_front();
         compare_field("record_type", want.record_type, got.record_type);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
         compare_field("stmt_kind", want.stmt_kind, got.stmt_kind);
         compare_field("opcode", want.opcode, got.opcode);
         compare_field("stmt_length", want.stmt_length, got.stmt_length);
         compare_field("string_count", want.string_count, got.string_count);
         compare_field("statement_total", want.statement_total, got.statement_total);
         compare_field("command_total", want.command_total, got.command_total);
         compare_field("expression_total", want.expression_total, got.expression_total);
         compare_field("unknown_total", want.unknown_total, got.unknown_total);
         compare_field("first_unknown_offset", want.first_unknown_offset,
                       got.first_unknown_offset);
         compare_field("walk_ok", want.walk_ok, got.walk_ok);
      end
      if (rsp_tuser) summ_checked++;
      else stmt_checked++;
   endtask

   // receiver: check each rsp transfer, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_record();
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("** script_statement_stream_walker_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // sender
   task automatic send_word(logic [15:0] w, bit last, bit lone);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      req_tlast <= last;
      req_tuser <= lone;
      do @(posedge clock); while (!req_tready);
      predict_word(w, last, lone);
      words_sent++;
   endtask

   // drop valid and hold off until every expected record has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_records.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // walk generation
   logic [15:0] code_q[$];
   bit          lone_end;

   function automatic bit starts_unknown(logic [15:0] w);
      return !((w >= sssw_pkg::TOK_OPEN_LO && w <= sssw_pkg::TOK_OPEN_HI) ||
               w == sssw_pkg::OP_JUMP ||
               (w >= sssw_pkg::CTL_LO && w <= sssw_pkg::CTL_HI) ||
               (w >= sssw_pkg::CMD_LO && w <= sssw_pkg::CMD_HI));
   endfunction

   function automatic void push_operands(int count);
      repeat (count) code_q.push_back(16'($urandom));
   endfunction

   function automatic void gen_expression();
      int          depth;
      int          r;
      logic [15:0] t;
      depth = 0;
      code_q.push_back(16'($urandom_range(sssw_pkg::TOK_OPEN_LO, sssw_pkg::TOK_OPEN_HI)));
      repeat ($urandom_range(0, 8)) begin
         r = $urandom_range(99);
         if (r < 15 && depth < 3) begin
            code_q.push_back(16'($urandom_range(sssw_pkg::TOK_OPEN_LO,
                                                sssw_pkg::TOK_OPEN_HI)));
            depth++;
         end else if (r < 30 && depth > 0) begin
            code_q.push_back(sssw_pkg::TOK_END);
            depth--;
         end else if (r < 50) begin
            code_q.push_back(sssw_pkg::TOK_STRING);
            push_operands(tok_args(sssw_pkg::TOK_STRING));
         end else if (r < 70) begin
            code_q.push_back(16'($urandom_range(sssw_pkg::OPR_LO, sssw_pkg::OPR_HI)));
         end else begin
            // words from the token scan range, or any word outside the open and close codes
            if (r < 85) begin
               t = 16'($urandom_range(TOK_SCAN_LO, TOK_SCAN_HI));
            end else begin
               do t = 16'($urandom);
               while ((t >= sssw_pkg::TOK_OPEN_LO && t <= sssw_pkg::TOK_OPEN_HI) ||
                      t == sssw_pkg::TOK_END);
            end
            code_q.push_back(t);
            push_operands(tok_args(t));
         end
      end
      repeat (depth + 1) code_q.push_back(sssw_pkg::TOK_END);
   endfunction

   function automatic void gen_statement();
      int          r;
      logic [15:0] op;
      r = $urandom_range(99);
      if (r < 40) begin
         gen_expression();
      end else if (r < 55) begin
         code_q.push_back(sssw_pkg::OP_JUMP);
         push_operands(sssw_pkg::JUMP_SKIP);
      end else if (r < 70) begin
         op = 16'($urandom_range(sssw_pkg::CTL_LO, sssw_pkg::CTL_HI));
         code_q.push_back(op);
         push_operands(ctl_args(op));
      end else if (r < 88) begin
         code_q.push_back(16'($urandom_range(sssw_pkg::CMD_LO, sssw_pkg::CMD_HI)));
      end else begin
         do op = 16'($urandom);
         while (!starts_unknown(op));
         code_q.push_back(op);
      end
   endfunction

   // one statement, cut short if it has more than one word, so the code ends inside it
   function automatic void gen_cut_statement();
      int base;
      int len;
      base = code_q.size();
      gen_statement();
      len = code_q.size() - base;
      if (len > 1) repeat ($urandom_range(1, len - 1)) void'(code_q.pop_back());
   endfunction

   function automatic void gen_walk();
      int r;
      code_q.delete();
      lone_end = 1'b0;
      r = $urandom_range(99);
      if (r < 88) begin
         repeat ($urandom_range(1, 10)) gen_statement();
         if (r >= 65 && r < 78) begin
            gen_cut_statement();
         end else if (r >= 78) begin
            if ($urandom_range(1)) gen_cut_statement();
            code_q.push_back(16'($urandom));
            lone_end = 1'b1;
         end
      end else begin
         // noise
         repeat ($urandom_range(1, 16)) code_q.push_back(16'($urandom));
         lone_end = ($urandom_range(4) == 0);
      end
   endfunction

   task automatic send_walk();
      int  last_idx;
      bit  last;
      last_idx = code_q.size() - 1;
      for (int i = 0; i <= last_idx; i++) begin
         last = (i == last_idx) && (!lone_end || $urandom_range(1));
         send_word(code_q[i], last, lone_end && (i == last_idx));
      end
      walks_sent++;
   endtask

   // ------------------------------------------------------------------
   // tests

   // every statement kind, opcode range ends and nested expressions in one walk
   task automatic test_statement_kinds();
      code_q = '{sssw_pkg::CMD_LO, sssw_pkg::CMD_HI,
                 sssw_pkg::OP_JUMP, 16'h0000, 16'hFFFF,
                 CTL_ARG4, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF,
                 CTL_NOARG,
                 sssw_pkg::TOK_OPEN_HI, sssw_pkg::TOK_STRING, 16'h1234, 16'hFEDC,
                 sssw_pkg::TOK_OPEN_LO, sssw_pkg::OPR_HI, sssw_pkg::TOK_END,
                 sssw_pkg::TOK_END,
                 OP_UNKNOWN_TOP};
      lone_end = 1'b0;
      send_walk();
   endtask

   // lone byte alone, code ending inside a jump, a clean one-command walk
   task automatic test_walk_endings();
      send_word(16'hFF5A, 1'b0, 1'b1);
      send_word(sssw_pkg::OP_JUMP, 1'b0, 1'b0);
      send_word(16'h00FF, 1'b1, 1'b0);
      send_word(sssw_pkg::CMD_LO + 16'h0123, 1'b1, 1'b0);
      walks_sent += 3;
   endtask

   // deepest legal nesting closes cleanly; one more level stops the walk
   task automatic test_nesting_limits();
      for (int extra = 0; extra <= 1; extra++) begin
         code_q.delete();
         lone_end = 1'b0;
         code_q.push_back(16'($urandom_range(sssw_pkg::TOK_OPEN_LO, sssw_pkg::TOK_OPEN_HI)));
         repeat (NEST_LIMIT + extra) begin
            if ($urandom_range(3) == 0)
               code_q.push_back(16'($urandom_range(sssw_pkg::OPR_LO, sssw_pkg::OPR_HI)));
            code_q.push_back(16'($urandom_range(sssw_pkg::TOK_OPEN_LO,
                                                sssw_pkg::TOK_OPEN_HI)));
         end
         if (extra == 0) begin
            repeat (NEST_LIMIT + 1) code_q.push_back(sssw_pkg::TOK_END);
         end else begin
            // words after the overflow are ignored by the walk
            repeat (NEST_LIMIT + 1) code_q.push_back(sssw_pkg::TOK_END);
            code_q.push_back(16'($urandom_range(sssw_pkg::CMD_LO, sssw_pkg::CMD_HI)));
         end
         gen_statement();
         send_walk();
      end
   endtask

   task automatic test_random_walks(int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         gen_walk();
         send_walk();
         sent += code_q.size();
      end
   endtask

   // ------------------------------------------------------------------
   initial begin
      walk_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle = 21;
      recv_idle = 54;
      test_statement_kinds();
      test_walk_endings();
      wait_drained();
      test_nesting_limits();
      test_random_walks(250);
      wait_drained();

      send_idle = 54;
      recv_idle = 21;
      test_random_walks(250);
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      test_random_walks(250);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (pending_records.size() != 0) begin
         $display("%0t: %0d expected records never arrived", $time,
                  pending_records.size());
         mismatches++;
      end
      $display("Sent %0d code words in %0d walks under three idle mixes.",
               words_sent, walks_sent);
      $display("Checked %0d statement records and %0d walk summaries, %0d mismatches.",
               stmt_checked, summ_checked, mismatches);
      if (mismatches == 0) begin
         $display("** script_statement_stream_walker_top: PASSED **");
      end else begin
         $display("** script_statement_stream_walker_top: FAILED **");
      end
      $finish;
   end

endmodule
